[src/arcs_pkg.sv]
// Shared types and constants of the adaptive route channel selector.
`timescale 1ns / 1ps

package arcs_pkg;

    localparam int VNETS = 4;

    localparam logic [1:0] OP_ROUTE  = 2'd0;
    localparam logic [1:0] OP_REJECT = 2'd1;
    localparam logic [1:0] OP_ACCEPT = 2'd2;

    localparam logic [1:0] STAGE_AX  = 2'd0;
    localparam logic [1:0] STAGE_AY  = 2'd1;
    localparam logic [1:0] STAGE_AZ  = 2'd2;
    localparam logic [1:0] STAGE_ESC = 2'd3;

    localparam logic [2:0] PORT_LOCAL = 3'd0;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl;

endpackage

[src/arcs_ctrl.sv]
// Controller state machine that sequences one beat through the datapath.
`timescale 1ns / 1ps

module arcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output arcs_pkg::t_ctrl o_cmd
);

    arcs_pkg::t_state r_state;
    arcs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            arcs_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = arcs_pkg::ST_EXEC;
                end
            end
            arcs_pkg::ST_EXEC: begin
                n_state = arcs_pkg::ST_IDLE;
            end
            default: begin
                n_state = arcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy      = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            arcs_pkg::ST_IDLE: begin
                o_cmd.load = i_start;
            end
            arcs_pkg::ST_EXEC: begin
                o_busy     = 1'b1;
                o_cmd.exec = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    // An accepted beat is executed in exactly the following cycle.
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("accepted beat was not executed");

    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_cmd.exec)
        else $error("execute lasted more than one cycle");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_busy))
        else $error("beat loaded while busy");

endmodule

[src/arcs_datapath.sv]
// Datapath: operand capture, retry stage table and route decision.
`timescale 1ns / 1ps

module arcs_datapath #(
    parameter int INPUTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  arcs_pkg::t_ctrl   i_cmd,
    input  logic [1:0]        i_operation,
    input  logic [2:0]        i_port_index,
    input  logic signed [7:0] i_delta_x,
    input  logic signed [7:0] i_delta_y,
    input  logic signed [7:0] i_delta_z,
    input  logic [2:0]        i_virtual_net,
    input  logic              i_ordered,
    input  logic              i_bubble_ok,
    output logic              o_valid,
    output logic              o_granted,
    output logic [2:0]        o_out_port,
    output logic [3:0]        o_header_channel,
    output logic [3:0]        o_request_channel,
    output logic              o_requeue,
    output logic              o_route_error
);

    localparam int IW = (INPUTS > 1) ? $clog2(INPUTS) : 1;

    logic [1:0]        r_op;
    logic [2:0]        r_port;
    logic signed [7:0] r_dx;
    logic signed [7:0] r_dy;
    logic signed [7:0] r_dz;
    logic [2:0]        r_vnet;
    logic              r_ordered;
    logic              r_bubble;

    logic [1:0]        r_stage [INPUTS];

    logic              r_valid;
    logic              r_granted;
    logic [2:0]        r_out_port;
    logic [3:0]        r_hch;
    logic [3:0]        r_rch;
    logic              r_requeue;
    logic              r_error;

    logic              n_granted;
    logic [2:0]        n_out_port;
    logic [3:0]        n_hch;
    logic [3:0]        n_rch;
    logic              n_requeue;
    logic              n_error;
    logic [1:0]        n_stage;
    logic              w_stage_we;

    logic [IW-1:0]     w_idx;
    logic              w_in_range;
    logic [1:0]        w_cur_stage;
    logic [1:0]        w_start_stage;
    logic [2:0]        w_gt;
    logic [2:0]        w_neg;
    logic              w_arrived;
    logic [2:0]        w_vsat;
    logic [3:0]        w_odd_ch;
    logic [3:0]        w_even_ch;
    logic [1:0]        w_esc_dim;

    function automatic logic [2:0] dir_port(input logic [1:0] dim, input logic neg);
        logic [2:0] code;
        code = {dim, 1'b0} + 3'd1 + {2'b00, neg};
        return code;
    endfunction

    function automatic logic above_one(input logic signed [7:0] d);
        return (d > 8'sd1) || (d < -8'sd1);
    endfunction

    function automatic logic unit_mag(input logic signed [7:0] d);
        return (d == 8'sd1) || (d == -8'sd1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_port    <= i_port_index;
            r_dx      <= i_delta_x;
            r_dy      <= i_delta_y;
            r_dz      <= i_delta_z;
            r_vnet    <= i_virtual_net;
            r_ordered <= i_ordered;
            r_bubble  <= i_bubble_ok;
        end
    end

    assign w_idx       = IW'(r_port);
    assign w_in_range  = (32'(r_port) < INPUTS);
    assign w_cur_stage = w_in_range ? r_stage[w_idx] : arcs_pkg::STAGE_AX;
    assign w_gt        = {above_one(r_dz), above_one(r_dy), above_one(r_dx)};
    assign w_neg       = {r_dz[7], r_dy[7], r_dx[7]};
    assign w_arrived   = unit_mag(r_dx) && unit_mag(r_dy) && unit_mag(r_dz);
    assign w_start_stage = r_ordered ? arcs_pkg::STAGE_ESC : w_cur_stage;
    assign w_esc_dim   = w_gt[0] ? 2'd0 : (w_gt[1] ? 2'd1 : 2'd2);

    always_comb begin
        if (r_vnet == 3'd0) begin
            w_vsat = 3'd1;
        end else if (int'(r_vnet) > arcs_pkg::VNETS) begin
            w_vsat = 3'(arcs_pkg::VNETS);
        end else begin
            w_vsat = r_vnet;
        end
    end

    assign w_odd_ch  = {w_vsat - 3'd1, 1'b1};
    assign w_even_ch = {w_vsat, 1'b0};

    always_comb begin
        n_granted  = 1'b0;
        n_out_port = arcs_pkg::PORT_LOCAL;
        n_hch      = 4'd0;
        n_rch      = 4'd0;
        n_requeue  = 1'b0;
        n_error    = 1'b0;
        n_stage    = arcs_pkg::STAGE_AX;
        w_stage_we = 1'b0;
        if (w_in_range) begin
            case (r_op)
                arcs_pkg::OP_ROUTE: begin
                    w_stage_we = 1'b1;
                    if (w_arrived) begin
                        n_granted = 1'b1;
                        n_hch     = 4'd1;
                        n_rch     = 4'd1;
                    end else if (w_start_stage == arcs_pkg::STAGE_AX && w_gt[0]) begin
                        n_granted  = 1'b1;
                        n_out_port = dir_port(2'd0, w_neg[0]);
                        n_hch      = w_odd_ch;
                        n_rch      = w_even_ch;
                        n_stage    = arcs_pkg::STAGE_AY;
                    end else if (w_start_stage <= arcs_pkg::STAGE_AY && w_gt[1]) begin
                        n_granted  = 1'b1;
                        n_out_port = dir_port(2'd1, w_neg[1]);
                        n_hch      = w_odd_ch;
                        n_rch      = w_even_ch;
                        n_stage    = arcs_pkg::STAGE_AZ;
                    end else if (w_start_stage <= arcs_pkg::STAGE_AZ && w_gt[2]) begin
                        n_granted  = 1'b1;
                        n_out_port = dir_port(2'd2, w_neg[2]);
                        n_hch      = w_odd_ch;
                        n_rch      = w_even_ch;
                        n_stage    = arcs_pkg::STAGE_ESC;
                    end else if (w_gt == 3'b000) begin
                        n_error = 1'b1;
                    end else if (r_bubble) begin
                        n_granted  = 1'b1;
                        n_out_port = dir_port(w_esc_dim, w_neg[w_esc_dim]);
                        n_hch      = w_even_ch;
                        n_rch      = w_odd_ch;
                        n_stage    = arcs_pkg::STAGE_ESC;
                    end
                end
                arcs_pkg::OP_REJECT: begin
                    if (w_cur_stage == arcs_pkg::STAGE_ESC) begin
                        w_stage_we = 1'b1;
                        n_requeue  = 1'b1;
                    end
                end
                arcs_pkg::OP_ACCEPT: begin
                    w_stage_we = 1'b1;
                end
                default: begin
                    w_stage_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < INPUTS; i++) begin
                r_stage[i] <= arcs_pkg::STAGE_AX;
            end
        end else if (i_cmd.exec && w_stage_we) begin
            r_stage[w_idx] <= n_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_granted  <= n_granted;
            r_out_port <= n_out_port;
            r_hch      <= n_hch;
            r_rch      <= n_rch;
            r_requeue  <= n_requeue;
            r_error    <= n_error;
        end
    end

    assign o_valid           = r_valid;
    assign o_granted         = r_granted;
    assign o_out_port        = r_out_port;
    assign o_header_channel  = r_hch;
    assign o_request_channel = r_rch;
    assign o_requeue         = r_requeue;
    assign o_route_error     = r_error;

    a_valid_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(i_cmd.exec))
        else $error("result beat without an executed request");

    a_error_not_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_error |-> !r_granted && r_out_port == arcs_pkg::PORT_LOCAL)
        else $error("routing error reported together with a grant");

    a_requeue_leaves_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && n_requeue |=> r_stage[$past(w_idx)] == arcs_pkg::STAGE_AX)
        else $error("requeued port did not return to the adaptive X stage");

endmodule

[src/adaptive_route_channel_selector_top.sv]
// Top level of the adaptive route channel selector.
`timescale 1ns / 1ps

// Channel   | Handshake               | Beat contents
// ----------+-------------------------+-----------------------------------------------
// request   | start, busy             | operation, port index, deltas, vnet, flags
// result    | o_valid (one cycle)     | granted, port, channels, requeue, route error
//
// Every beat passes through capture, then a decision state that reads and
// updates the retry stage of the addressed port. The result strobe rises in the
// cycle after the decision, when busy has already fallen, so a new beat can be
// taken in that cycle. Reset clears all retry stages to adaptive X at once.
// The result receiver cannot stall the block.

module adaptive_route_channel_selector_top #(
    parameter int INPUTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_operation,
    input  logic [2:0]        i_port_index,
    input  logic signed [7:0] i_delta_x,
    input  logic signed [7:0] i_delta_y,
    input  logic signed [7:0] i_delta_z,
    input  logic [2:0]        i_virtual_net,
    input  logic              i_ordered,
    input  logic              i_bubble_ok,
    output logic              o_valid,
    output logic              o_granted,
    output logic [2:0]        o_out_port,
    output logic [3:0]        o_header_channel,
    output logic [3:0]        o_request_channel,
    output logic              o_requeue,
    output logic              o_route_error
);

    arcs_pkg::t_ctrl w_cmd;

    arcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    arcs_datapath #(
        .INPUTS (INPUTS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_operation       (i_operation),
        .i_port_index      (i_port_index),
        .i_delta_x         (i_delta_x),
        .i_delta_y         (i_delta_y),
        .i_delta_z         (i_delta_z),
        .i_virtual_net     (i_virtual_net),
        .i_ordered         (i_ordered),
        .i_bubble_ok       (i_bubble_ok),
        .o_valid           (o_valid),
        .o_granted         (o_granted),
        .o_out_port        (o_out_port),
        .o_header_channel  (o_header_channel),
        .o_request_channel (o_request_channel),
        .o_requeue         (o_requeue),
        .o_route_error     (o_route_error)
    );

endmodule

[bench/tb_adaptive_route_channel_selector_top.sv]
// Self-checking testbench for the route channel selector: directed table plus random beats.
`timescale 1ns / 1ps

module tb_adaptive_route_channel_selector_top;

    localparam logic [1:0] OP_ROUTE   = arcs_pkg::OP_ROUTE;
    localparam logic [1:0] OP_REJECT  = arcs_pkg::OP_REJECT;
    localparam logic [1:0] OP_ACCEPT  = arcs_pkg::OP_ACCEPT;
    localparam logic [1:0] STAGE_AX   = arcs_pkg::STAGE_AX;
    localparam logic [1:0] STAGE_ESC  = arcs_pkg::STAGE_ESC;
    localparam logic [2:0] PORT_LOCAL = arcs_pkg::PORT_LOCAL;
    localparam int VNETS = arcs_pkg::VNETS;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] PORT_XP = 3'd1;
    localparam logic [2:0] PORT_XM = 3'd2;
    localparam logic [2:0] PORT_YP = 3'd3;
    localparam logic [2:0] PORT_YM = 3'd4;
    localparam logic [2:0] PORT_ZP = 3'd5;
    localparam logic [2:0] PORT_ZM = 3'd6;
    localparam int NUM_PORTS = 8;
    localparam int RANDOM_BEATS = 600;
    localparam int CYCLE_LIMIT = 60000;

    typedef struct packed {
        logic [1:0]        op;
        logic [2:0]        port;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic signed [7:0] dz;
        logic [2:0]        vnet;
        logic              ordered;
        logic              bubble;
    } t_route_req;

    typedef struct packed {
        logic       granted;
        logic [2:0] out_port;
        logic [3:0] hdr_ch;
        logic [3:0] req_ch;
        logic       requeue;
        logic       route_error;
    } t_route_res;

    typedef struct packed {
        t_route_req req;
        logic       has_exp;
        t_route_res exp;
    } t_dir_row;

    localparam t_route_res CLEAR_RES = '0;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_operation;
    logic [2:0]        i_port_index;
    logic signed [7:0] i_delta_x;
    logic signed [7:0] i_delta_y;
    logic signed [7:0] i_delta_z;
    logic [2:0]        i_virtual_net;
    logic              i_ordered;
    logic              i_bubble_ok;
    logic              o_valid;
    logic              o_granted;
    logic [2:0]        o_out_port;
    logic [3:0]        o_header_channel;
    logic [3:0]        o_request_channel;
    logic              o_requeue;
    logic              o_route_error;

    logic [1:0]  stage_tbl [NUM_PORTS];
    t_route_res  pending_routes [$];
    logic        typed_valid = 1'b0;
    t_route_res  typed_res = '0;
    int unsigned beats_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned n_adaptive = 0;
    int unsigned n_escape = 0;
    int unsigned n_requeue = 0;
    int unsigned n_route_err = 0;
    int unsigned n_refused = 0;

    adaptive_route_channel_selector_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_port_index      (i_port_index),
        .i_delta_x         (i_delta_x),
        .i_delta_y         (i_delta_y),
        .i_delta_z         (i_delta_z),
        .i_virtual_net     (i_virtual_net),
        .i_ordered         (i_ordered),
        .i_bubble_ok       (i_bubble_ok),
        .o_valid           (o_valid),
        .o_granted         (o_granted),
        .o_out_port        (o_out_port),
        .o_header_channel  (o_header_channel),
        .o_request_channel (o_request_channel),
        .o_requeue         (o_requeue),
        .o_route_error     (o_route_error)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic has_hops(input logic signed [7:0] d);
        return (d > 8'sd1) || (d < -8'sd1);
    endfunction

    function automatic logic [2:0] dir_code(input int dim, input logic signed [7:0] d);
        logic neg;
        neg = (d <= 8'sd0);
        case (dim)
            0: return neg ? PORT_XM : PORT_XP;
            1: return neg ? PORT_YM : PORT_YP;
            default: return neg ? PORT_ZM : PORT_ZP;
        endcase
    endfunction

    // Works out the result of one beat and updates the retry stage of its port.
    function automatic t_route_res route_select(input t_route_req rq);
        t_route_res        res;
        logic [1:0]        st;
        logic signed [7:0] d [3];
        int unsigned       v;
        logic [3:0]        odd_ch;
        logic [3:0]        even_ch;
        logic              done;
        int                dim;
        res = '0;
        d[0] = rq.dx;
        d[1] = rq.dy;
        d[2] = rq.dz;
        v = 32'(rq.vnet);
        if (v < 1) v = 1;
        if (v > 32'(VNETS)) v = 32'(VNETS);
        odd_ch = 4'((v - 1) * 2 + 1);
        even_ch = 4'(2 * v);
        st = stage_tbl[rq.port];
        case (rq.op)
            OP_ROUTE: begin
                if (!has_hops(d[0]) && d[0] != 8'sd0 && !has_hops(d[1]) && d[1] != 8'sd0
                        && !has_hops(d[2]) && d[2] != 8'sd0) begin
                    res.granted = 1'b1;
                    res.out_port = PORT_LOCAL;
                    res.hdr_ch = 4'd1;
                    res.req_ch = 4'd1;
                    st = STAGE_AX;
                end else begin
                    if (rq.ordered) st = STAGE_ESC;
                    done = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        if (!done && st == 2'(i)) begin
                            st = st + 2'd1;
                            if (has_hops(d[i])) begin
                                res.granted = 1'b1;
                                res.out_port = dir_code(i, d[i]);
                                res.hdr_ch = odd_ch;
                                res.req_ch = even_ch;
                                done = 1'b1;
                            end
                        end
                    end
                    if (!done) begin
                        dim = -1;
                        for (int i = 2; i >= 0; i--) begin
                            if (has_hops(d[i])) dim = i;
                        end
                        if (dim < 0) begin
                            res.route_error = 1'b1;
                            st = STAGE_AX;
                        end else if (!rq.bubble) begin
                            st = STAGE_AX;
                        end else begin
                            res.granted = 1'b1;
                            res.out_port = dir_code(dim, d[dim]);
                            res.hdr_ch = even_ch;
                            res.req_ch = odd_ch;
                        end
                    end
                end
            end
            OP_REJECT: begin
                if (st == STAGE_ESC) begin
                    st = STAGE_AX;
                    res.requeue = 1'b1;
                end
            end
            OP_ACCEPT: begin
                st = STAGE_AX;
            end
            default: begin
            end
        endcase
        stage_tbl[rq.port] = st;
        return res;
    endfunction

    function automatic logic signed [7:0] rand_delta();
        logic signed [7:0] mag;
        mag = 8'($urandom_range(2, 10));
        case ($urandom_range(0, 9))
            0: return 8'sd0;
            1, 2, 3: return $urandom_range(0, 1) ? 8'sd1 : -8'sd1;
            4, 5, 6, 7: return $urandom_range(0, 1) ? mag : -mag;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_route_req rand_request();
        t_route_req  rq;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) rq.op = OP_ROUTE;
        else if (pick < 78) rq.op = OP_REJECT;
        else if (pick < 94) rq.op = OP_ACCEPT;
        else rq.op = OP_UNUSED;
        rq.port = 3'($urandom_range(0, NUM_PORTS - 1));
        if ($urandom_range(0, 99) < 8) begin
            rq.dx = $urandom_range(0, 1) ? 8'sd1 : -8'sd1;
            rq.dy = $urandom_range(0, 1) ? 8'sd1 : -8'sd1;
            rq.dz = $urandom_range(0, 1) ? 8'sd1 : -8'sd1;
        end else begin
            rq.dx = rand_delta();
            rq.dy = rand_delta();
            rq.dz = rand_delta();
        end
        rq.vnet = ($urandom_range(0, 99) < 15) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, VNETS));
        rq.ordered = ($urandom_range(0, 99) < 25);
        rq.bubble = ($urandom_range(0, 99) < 70);
        return rq;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_route_res exp_r;
        t_route_res pred;
        t_route_req rq;
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PORTS; p++) stage_tbl[p] = STAGE_AX;
        end else begin
            if (o_valid) begin
                results_seen++;
                if (pending_routes.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected", $time);
                end else begin
                    exp_r = pending_routes.pop_front();
                    check_field("granted", 32'(exp_r.granted), 32'(o_granted));
                    check_field("out_port", 32'(exp_r.out_port), 32'(o_out_port));
                    check_field("header_channel", 32'(exp_r.hdr_ch), 32'(o_header_channel));
                    check_field("request_channel", 32'(exp_r.req_ch), 32'(o_request_channel));
                    check_field("requeue", 32'(exp_r.requeue), 32'(o_requeue));
                    check_field("route_error", 32'(exp_r.route_error), 32'(o_route_error));
                end
            end
            if (start && !busy) begin
                rq = '{i_operation, i_port_index, i_delta_x, i_delta_y, i_delta_z,
                       i_virtual_net, i_ordered, i_bubble_ok};
                pred = route_select(rq);
                if (pred.granted) begin
                    if (pred.hdr_ch[0]) n_adaptive++;
                    else n_escape++;
                end
                if (rq.op == OP_ROUTE && !pred.granted && !pred.route_error) n_refused++;
                if (pred.requeue) n_requeue++;
                if (pred.route_error) n_route_err++;
                pending_routes.push_back(typed_valid ? typed_res : pred);
                beats_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_routes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_beat(input t_route_req rq, input logic has_exp, input t_route_res exp_r);
        int unsigned seen;
        seen = beats_taken;
        i_operation <= rq.op;
        i_port_index <= rq.port;
        i_delta_x <= rq.dx;
        i_delta_y <= rq.dy;
        i_delta_z <= rq.dz;
        i_virtual_net <= rq.vnet;
        i_ordered <= rq.ordered;
        i_bubble_ok <= rq.bubble;
        start <= 1'b1;
        typed_valid = has_exp;
        typed_res = exp_r;
        while (beats_taken == seen) @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_routes.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_dir_row   dir_rows [20];
        t_route_req rq;
        dir_rows = '{
            '{'{OP_ROUTE, 3'd0, 8'sd1, 8'sd1, -8'sd1, 3'd1, 1'b0, 1'b1}, 1'b1,
              '{1'b1, PORT_LOCAL, 4'd1, 4'd1, 1'b0, 1'b0}},
            '{'{OP_ROUTE, 3'd1, 8'sd5, 8'sd0, 8'sd0, 3'd2, 1'b0, 1'b1}, 1'b0, CLEAR_RES},
            '{'{OP_ROUTE, 3'd1, 8'sd5, -8'sd3, 8'sd0, 3'd2, 1'b0, 1'b1}, 1'b0, CLEAR_RES},
            '{'{OP_ROUTE, 3'd1, 8'sd0, 8'sd0, 8'sd64, 3'd3, 1'b0, 1'b1}, 1'b0, CLEAR_RES},
            '{'{OP_ROUTE, 3'd1, -8'sd64, 8'sd0, 8'sd0, 3'd3, 1'b0, 1'b0}, 1'b1, CLEAR_RES},
            '{'{OP_ROUTE, 3'd2, 8'sd127, 8'sd0, 8'sd0, 3'd4, 1'b1, 1'b1}, 1'b0, CLEAR_RES},
            '{'{OP_REJECT, 3'd2, 8'sd0, 8'sd0, 8'sd0, 3'd1, 1'b0, 1'b0}, 1'b1,
              '{1'b0, PORT_LOCAL, 4'd0, 4'd0, 1'b1, 1'b0}},
            '{'{OP_REJECT, 3'd2, 8'sd0, 8'sd0, 8'sd0, 3'd1, 1'b0, 1'b0}, 1'b1, CLEAR_RES},
            '{'{OP_ROUTE, 3'd3, 8'sd0, 8'sd0, 8'sd0, 3'd1, 1'b1, 1'b1}, 1'b1,
              '{1'b0, PORT_LOCAL, 4'd0, 4'd0, 1'b0, 1'b1}},
            '{'{OP_ROUTE, 3'd4, 8'h80, 8'h80, 8'h80, 3'd0, 1'b0, 1'b1}, 1'b0, CLEAR_RES},
            '{'{OP_ROUTE, 3'd4, 8'sd1, 8'sd1, 8'sd0, 3'd7, 1'b0, 1'b1}, 1'b0, CLEAR_RES},
            '{'{OP_ACCEPT, 3'd5, -8'sd9, 8'sd7, 8'sd2, 3'd6, 1'b1, 1'b1}, 1'b1, CLEAR_RES},
            '{'{OP_UNUSED, 3'd6, 8'sd4, 8'sd4, 8'sd4, 3'd2, 1'b1, 1'b1}, 1'b1, CLEAR_RES},
            '{'{OP_ROUTE, 3'd7, 8'sd1, -8'sd1, 8'h80, 3'd2, 1'b0, 1'b1}, 1'b0, CLEAR_RES},
            '{'{OP_ROUTE, 3'd7, 8'sd2, 8'sd0, 8'sd0, 3'd2, 1'b0, 1'b1}, 1'b0, CLEAR_RES},
            '{'{OP_ACCEPT, 3'd7, 8'sd0, 8'sd0, 8'sd0, 3'd1, 1'b0, 1'b0}, 1'b1, CLEAR_RES},
            '{'{OP_ROUTE, 3'd6, 8'sd0, -8'sd2, 8'sd0, 3'd3, 1'b1, 1'b0}, 1'b1, CLEAR_RES},
            '{'{OP_ROUTE, 3'd0, -8'sd1, 8'sd1, 8'sd1, 3'd4, 1'b1, 1'b0}, 1'b1,
              '{1'b1, PORT_LOCAL, 4'd1, 4'd1, 1'b0, 1'b0}},
            '{'{OP_ROUTE, 3'd3, 8'sd2, 8'sd2, 8'sd2, 3'd3, 1'b0, 1'b1}, 1'b0, CLEAR_RES},
            '{'{OP_REJECT, 3'd3, 8'sd0, 8'sd0, 8'sd0, 3'd3, 1'b0, 1'b1}, 1'b1, CLEAR_RES}
        };
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_operation <= OP_ROUTE;
        i_port_index <= 3'd0;
        i_delta_x <= 8'sd0;
        i_delta_y <= 8'sd0;
        i_delta_z <= 8'sd0;
        i_virtual_net <= 3'd1;
        i_ordered <= 1'b0;
        i_bubble_ok <= 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) send_beat(dir_rows[r].req, dir_rows[r].has_exp, dir_rows[r].exp);
        drain_results();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // Beats 200 to 359 go back to back, apart from a drain before beat 300; the rest may see random gaps.
            if (n == 300) drain_results();
            if ((n < 200 || n >= 360) && $urandom_range(0, 99) < 23) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end
            rq = rand_request();
            send_beat(rq, 1'b0, CLEAR_RES);
        end
        drain_results();
        repeat (6) @(negedge i_clk);

        $display("Checked %0d result beats: %0d adaptive and %0d escape grants, %0d refused,",
                 results_seen, n_adaptive, n_escape, n_refused);
        $display("%0d requeues and %0d route errors; %0d mismatches.",
                 n_requeue, n_route_err, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
